### rtl/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types and constants of the fixed block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

	localparam int ADDR_W         = 32;
	localparam int BLOCK_W        = 16;
	localparam int POOL_W         = 24;
	localparam int STATUS_W       = 2;
	localparam int DEF_MAX_BLOCKS = 256;

	// APB register map, one 32-bit word per register
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_BASE  = 2'd0;
	localparam reg_idx_t REG_BLOCK = 2'd1;
	localparam reg_idx_t REG_POOL  = 2'd2;

	localparam logic [ADDR_W-1:0]  RST_BASE  = 32'd0;
	localparam logic [BLOCK_W-1:0] RST_BLOCK = 16'd64;
	localparam logic [POOL_W-1:0]  RST_POOL  = 24'd16384;

	typedef logic [STATUS_W-1:0] status_t;
	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_EMPTY   = 2'd1;
	localparam status_t ST_BADADDR = 2'd2;
	localparam status_t ST_FULL    = 2'd3;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} opcode_t;

endpackage

### rtl/fbpa_if.sv
// ----------------------------------------------------------------------------
// fbpa_req_if / fbpa_rsp_if
// Valid/ready channels carrying allocator requests and responses.
// ----------------------------------------------------------------------------
interface fbpa_req_if;
	logic                       valid;
	logic                       ready;
	logic                       opcode;
	logic [fbpa_pkg::ADDR_W-1:0] free_addr;

	modport source (output valid, output opcode, output free_addr, input ready);
	modport sink   (input valid, input opcode, input free_addr, output ready);
endinterface

interface fbpa_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [fbpa_pkg::STATUS_W-1:0] status;
	logic [fbpa_pkg::ADDR_W-1:0]   block_addr;

	modport source (output valid, output status, output block_addr, input ready);
	modport sink   (input valid, input status, input block_addr, output ready);
endinterface

### rtl/fixed_block_pool_allocator.sv
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Equal-sized block allocator: LIFO free stack plus bump pointer.
// ----------------------------------------------------------------------------
// One request is handled at a time. An allocate goes from S_ALLOC to S_DONE
// (via S_POP when it pops the free stack, whose memory read is registered).
// A free runs a range check, then a bit-serial restoring remainder unit that
// retires one bit of the 24-bit pool offset per cycle to test block
// alignment, then the push. A free whose address fails the range check skips
// the remainder unit. The response sits in an output register, so the next
// request is taken while an earlier response waits. The free stack memory
// holds MAX_BLOCKS entries; configuration goes through the APB port at byte
// addresses 0 (base), 4 (block size) and 8 (pool size).
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator #(
	parameter int MAX_BLOCKS = fbpa_pkg::DEF_MAX_BLOCKS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [fbpa_pkg::PADDR_W-1:0] paddr,
	input  logic [fbpa_pkg::PDATA_W-1:0] pwdata,
	output logic [fbpa_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	fbpa_req_if.sink                     req,
	fbpa_rsp_if.source                   rsp
);
	import fbpa_pkg::*;

	localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
	localparam int IDX_W  = $clog2(MAX_BLOCKS);
	localparam int STEP_W = $clog2(POOL_W);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ALLOC,
		S_POP,
		S_CHECK,
		S_DIV,
		S_PUSH,
		S_DONE
	} state_t;

	state_t state_q;

	logic [ADDR_W-1:0]  base_q;
	logic [BLOCK_W-1:0] block_q;
	logic [POOL_W-1:0]  pool_q;

	logic [CNT_W-1:0]   count_q;
	logic [POOL_W-1:0]  bump_q;

	logic [ADDR_W-1:0]  addr_q;
	logic [POOL_W-1:0]  div_q;
	logic [BLOCK_W-1:0] rem_q;
	logic [STEP_W-1:0]  step_q;

	status_t            res_status_q;
	logic [ADDR_W-1:0]  res_addr_q;
	logic               out_valid_q;
	status_t            out_status_q;
	logic [ADDR_W-1:0]  out_addr_q;

	logic [ADDR_W-1:0]  mem [MAX_BLOCKS];
	logic [ADDR_W-1:0]  rd_data_q;

	// ---------------- configuration port ----------------
	logic     cfg_wr;
	reg_idx_t cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= RST_BASE;
			block_q <= RST_BLOCK;
			pool_q  <= RST_POOL;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_BASE:  base_q  <= pwdata;
				REG_BLOCK: block_q <= pwdata[BLOCK_W-1:0];
				REG_POOL:  pool_q  <= pwdata[POOL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_BASE:  prdata = base_q;
			REG_BLOCK: prdata = {{(PDATA_W-BLOCK_W){1'b0}}, block_q};
			REG_POOL:  prdata = {{(PDATA_W-POOL_W){1'b0}}, pool_q};
			default:   prdata = '0;
		endcase
	end

	// ---------------- datapath ----------------
	logic              block_nz;
	logic              stack_nz;
	logic              stack_full;
	logic [CNT_W-1:0]  count_dec;
	logic [POOL_W:0]   bump_sum;
	logic              bump_ok;
	logic [ADDR_W-1:0] off;
	logic [ADDR_W:0]   off_end;
	logic              range_ok;
	logic [BLOCK_W:0]  rem_shift;
	logic [BLOCK_W:0]  rem_diff;
	logic [BLOCK_W-1:0] rem_next;
	logic              mem_we;
	logic              mem_re;

	assign block_nz   = (block_q != '0);
	assign stack_nz   = (count_q != '0);
	assign stack_full = (count_q == CNT_W'(MAX_BLOCKS));
	assign count_dec  = count_q - 1'b1;

	assign bump_sum = {1'b0, bump_q} + {{(POOL_W-BLOCK_W+1){1'b0}}, block_q};
	assign bump_ok  = block_nz && (bump_sum <= {1'b0, pool_q});

	// exact range check: the whole block must sit inside the pool
	assign off      = addr_q - base_q;
	assign off_end  = {1'b0, off} + {{(ADDR_W-BLOCK_W+1){1'b0}}, block_q};
	assign range_ok = block_nz && (addr_q >= base_q)
		&& (off_end <= {{(ADDR_W-POOL_W+1){1'b0}}, pool_q});

	// one restoring remainder step per cycle
	assign rem_shift = {rem_q, div_q[POOL_W-1]};
	assign rem_diff  = rem_shift - {1'b0, block_q};
	assign rem_next  = (rem_shift >= {1'b0, block_q}) ? rem_diff[BLOCK_W-1:0]
		: rem_shift[BLOCK_W-1:0];

	assign mem_re = (state_q == S_ALLOC) && stack_nz;
	assign mem_we = (state_q == S_PUSH) && (rem_q == '0) && !stack_full;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[count_q[IDX_W-1:0]] <= addr_q;
		end
		if (mem_re) begin
			rd_data_q <= mem[count_dec[IDX_W-1:0]];
		end
	end

	// ---------------- sequencer ----------------
	assign req.ready      = (state_q == S_IDLE);
	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_status_q;
	assign rsp.block_addr = out_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			bump_q       <= '0;
			out_valid_q  <= 1'b0;
			addr_q       <= '0;
			div_q        <= '0;
			rem_q        <= '0;
			step_q       <= '0;
			res_status_q <= ST_OK;
			res_addr_q   <= '0;
			out_status_q <= ST_OK;
			out_addr_q   <= '0;
		end else begin
			// a response that is taken while another waits in S_DONE is replaced below
			if (rsp.ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						addr_q  <= req.free_addr;
						state_q <= (req.opcode == OP_FREE) ? S_CHECK : S_ALLOC;
					end
				end
				S_ALLOC: begin
					priority if (stack_nz) begin
						count_q <= count_dec;
						state_q <= S_POP;
					end else if (bump_ok) begin
						res_status_q <= ST_OK;
						res_addr_q   <= base_q + {{(ADDR_W-POOL_W){1'b0}}, bump_q};
						bump_q       <= bump_sum[POOL_W-1:0];
						state_q      <= S_DONE;
					end else begin
						res_status_q <= ST_EMPTY;
						res_addr_q   <= '0;
						state_q      <= S_DONE;
					end
				end
				S_POP: begin
					res_status_q <= ST_OK;
					res_addr_q   <= rd_data_q;
					state_q      <= S_DONE;
				end
				S_CHECK: begin
					res_addr_q <= '0;
					if (range_ok) begin
						div_q   <= off[POOL_W-1:0];
						rem_q   <= '0;
						step_q  <= '0;
						state_q <= S_DIV;
					end else begin
						res_status_q <= ST_BADADDR;
						state_q      <= S_DONE;
					end
				end
				S_DIV: begin
					rem_q  <= rem_next;
					div_q  <= {div_q[POOL_W-2:0], 1'b0};
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(POOL_W - 1)) begin
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					priority if (rem_q != '0) begin
						res_status_q <= ST_BADADDR;
					end else if (stack_full) begin
						res_status_q <= ST_FULL;
					end else begin
						res_status_q <= ST_OK;
						count_q      <= count_q + 1'b1;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					// hold until the output register is free
					if (!out_valid_q || rsp.ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_addr_q   <= res_addr_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
